@@ rtl/core/point_rotate_about_center_top_macros.svh @@
// Assertion macros for the point rotation block.
`ifndef POINT_ROTATE_ABOUT_CENTER_TOP_MACROS_SVH
`define POINT_ROTATE_ABOUT_CENTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/prc_pkg.sv @@
// Shared types and constants for the point rotation block.
`default_nettype none

package prc_pkg;

  localparam int unsigned CORDIC_STAGES_DEF = 16;

  // CORDIC gain 0.60725293500888 in Q29
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd326016437;

  // arctan(2^-i) in binary angle units, 2^32 per turn
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // One item as it moves through the CORDIC stages
  typedef struct packed {
    logic               vld;
    logic               flip;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } prc_cordic_t;

endpackage

`default_nettype wire

@@ rtl/core/prc_cordic_stage.sv @@
// One registered CORDIC rotation stage.
`default_nettype none

module prc_cordic_stage #(
  parameter int unsigned STAGE_IDX = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire prc_pkg::prc_cordic_t stage_i,
  output prc_pkg::prc_cordic_t      stage_o
);

  prc_pkg::prc_cordic_t st_r;
  prc_pkg::prc_cordic_t st_nxt;

  logic signed [31:0] x_in;
  logic signed [31:0] y_in;
  logic signed [31:0] z_in;
  logic signed [31:0] xs;
  logic signed [31:0] ys;
  logic signed [31:0] atan;

  always_comb begin
    x_in = stage_i.x;
    y_in = stage_i.y;
    z_in = stage_i.z;
    xs   = x_in >>> STAGE_IDX;
    ys   = y_in >>> STAGE_IDX;
    atan = signed'(prc_pkg::ATAN_TAB[STAGE_IDX]);
    st_nxt = stage_i;
    // steer toward zero residual angle
    if (!z_in[31]) begin
      st_nxt.x = x_in - ys;
      st_nxt.y = y_in + xs;
      st_nxt.z = z_in - atan;
    end else begin
      st_nxt.x = x_in + ys;
      st_nxt.y = y_in - xs;
      st_nxt.z = z_in + atan;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.vld <= 1'b0;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign stage_o = st_r;

endmodule

`default_nettype wire

@@ rtl/core/point_rotate_about_center_top.sv @@
// An accepted item passes registers s0 to s4, the CORDIC stages, then the trig, multiply,
// sum and output registers before the result strobe; the CORDIC chain is most of that path.
// Throughput: one item per cycle; busy stays low since the pipeline never stalls.
// Reset clears all stage valid bits and the center and angle registers to zero.
// The result strobe out_valid is high for one cycle per item.
`default_nettype none
`include "point_rotate_about_center_top_macros.svh"

module point_rotate_about_center_top #(
  parameter int unsigned CORDIC_STAGES = prc_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_wdata,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_command,
  input  wire logic signed [31:0] in_point_x,
  input  wire logic signed [31:0] in_point_y,
  output logic                    out_valid,
  output logic signed [31:0]      out_rotated_x,
  output logic signed [31:0]      out_rotated_y,
  output logic                    out_saturated
);

  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_ANGLE    = 2'd2;

  localparam logic signed [17:0] TURN_S    = 18'sd46080;
  localparam logic signed [17:0] TWO_TURNS = 18'sd92160;
  localparam logic [15:0] QUARTER_U  = 16'd11520;
  localparam logic [15:0] THREE_Q_U  = 16'd34560;
  localparam logic signed [16:0] HALF_S17 = 17'sd23040;
  localparam logic signed [16:0] TURN_S17 = 17'sd46080;
  localparam logic [13:0] QUARTER_MAG = 14'd11520;
  // floor(x / 45) = (x * 23302) >> 20 for x below 2^14
  localparam logic [28:0] RECIP45_20 = 29'd23302;
  localparam logic [21:0] RECIP45_16 = 22'd1457;
  // 2^22 / 45 = 93206 rem 34
  localparam logic [30:0] QUOT_2P22 = 31'd93206;
  localparam logic [10:0] REM_2P22  = 11'd34;
  localparam logic [10:0] HALF_DIV  = 11'd22;
  localparam logic signed [66:0] ROUND_HALF = 67'sd268435456;
  localparam logic signed [31:0] SAT_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

  // configuration registers
  logic signed [31:0] center_x_r;
  logic signed [31:0] center_y_r;
  logic signed [16:0] angle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      angle_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_X: center_x_r <= cfg_wdata;
        REG_CENTER_Y: center_y_r <= cfg_wdata;
        REG_ANGLE:    angle_r    <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  logic in_acc;
  assign busy   = 1'b0;
  assign in_acc = start & ~busy;

  // stage 0: negate angle when in_command is set, reduce it modulo one turn, offset point by center
  logic signed [17:0] ang_ext;
  logic signed [17:0] ang_neg;
  logic signed [17:0] ang_mod;
  logic               s0_vld_r;
  logic [15:0]        s0_ang_r;
  logic signed [32:0] s0_dx_r;
  logic signed [32:0] s0_dy_r;

  always_comb begin
    ang_ext = {angle_r[16], angle_r};
    ang_neg = in_command ? -ang_ext : ang_ext;
    if (ang_neg < -TURN_S) begin
      ang_mod = ang_neg + TWO_TURNS;
    end else if (ang_neg < 18'sd0) begin
      ang_mod = ang_neg + TURN_S;
    end else if (ang_neg >= TURN_S) begin
      ang_mod = ang_neg - TURN_S;
    end else begin
      ang_mod = ang_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= in_acc;
      s0_ang_r <= ang_mod[15:0];
      s0_dx_r  <= {in_point_x[31], in_point_x} - {center_x_r[31], center_x_r};
      s0_dy_r  <= {in_point_y[31], in_point_y} - {center_y_r[31], center_y_r};
    end
  end

  // stage 1: fold into a half turn around zero, split sign and magnitude
  logic signed [16:0] fold_v;
  logic signed [16:0] fold_abs;
  logic               fold_flip;
  logic               s1_vld_r;
  logic               s1_flip_r;
  logic               s1_neg_r;
  logic [13:0]        s1_mag_r;
  logic signed [32:0] s1_dx_r;
  logic signed [32:0] s1_dy_r;

  always_comb begin
    fold_flip = 1'b0;
    if (s0_ang_r > QUARTER_U && s0_ang_r < THREE_Q_U) begin
      fold_v    = signed'({1'b0, s0_ang_r}) - HALF_S17;
      fold_flip = 1'b1;
    end else if (s0_ang_r >= THREE_Q_U) begin
      fold_v = signed'({1'b0, s0_ang_r}) - TURN_S17;
    end else begin
      fold_v = signed'({1'b0, s0_ang_r});
    end
    fold_abs = fold_v[16] ? -fold_v : fold_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s0_vld_r;
      s1_flip_r <= fold_flip;
      s1_neg_r  <= fold_v[16];
      s1_mag_r  <= fold_abs[13:0];
      s1_dx_r   <= s0_dx_r;
      s1_dy_r   <= s0_dy_r;
    end
  end

  // stage 2: quotient of magnitude by 45
  logic [28:0]        q_prod;
  logic               s2_vld_r;
  logic               s2_flip_r;
  logic               s2_neg_r;
  logic [13:0]        s2_mag_r;
  logic [8:0]         s2_q_r;
  logic signed [32:0] s2_dx_r;
  logic signed [32:0] s2_dy_r;

  assign q_prod = 29'(s1_mag_r) * RECIP45_20;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r  <= s1_vld_r;
      s2_flip_r <= s1_flip_r;
      s2_neg_r  <= s1_neg_r;
      s2_mag_r  <= s1_mag_r;
      s2_q_r    <= q_prod[28:20];
      s2_dx_r   <= s1_dx_r;
      s2_dy_r   <= s1_dy_r;
    end
  end

  // stage 3: remainder of magnitude by 45
  logic [13:0]        q45;
  logic [13:0]        rem_full;
  logic               s3_vld_r;
  logic               s3_flip_r;
  logic               s3_neg_r;
  logic [8:0]         s3_q_r;
  logic [5:0]         s3_m_r;
  logic signed [32:0] s3_dx_r;
  logic signed [32:0] s3_dy_r;

  assign q45      = 14'(s2_q_r) * 14'd45;
  assign rem_full = s2_mag_r - q45;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r  <= s2_vld_r;
      s3_flip_r <= s2_flip_r;
      s3_neg_r  <= s2_neg_r;
      s3_q_r    <= s2_q_r;
      s3_m_r    <= rem_full[5:0];
      s3_dx_r   <= s2_dx_r;
      s3_dy_r   <= s2_dy_r;
    end
  end

  // stage 4: binary angle = q * 2^22 + round(m * 2^22 / 45)
  logic [10:0]        t_num;
  logic [21:0]        t_prod;
  logic [30:0]        m_term;
  logic [30:0]        zmag;
  logic signed [31:0] z_ext;
  logic               s4_vld_r;
  logic               s4_flip_r;
  logic signed [31:0] s4_z_r;
  logic signed [32:0] s4_dx_r;
  logic signed [32:0] s4_dy_r;

  always_comb begin
    t_num  = 11'(s3_m_r) * REM_2P22 + HALF_DIV;
    t_prod = 22'(t_num) * RECIP45_16;
    m_term = 31'(s3_m_r) * QUOT_2P22;
    zmag   = {s3_q_r, 22'b0} + m_term + 31'(t_prod[21:16]);
    z_ext  = signed'({1'b0, zmag});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r  <= s3_vld_r;
      s4_flip_r <= s3_flip_r;
      s4_z_r    <= s3_neg_r ? -z_ext : z_ext;
      s4_dx_r   <= s3_dx_r;
      s4_dy_r   <= s3_dy_r;
    end
  end

  // CORDIC chain
  prc_pkg::prc_cordic_t cst [CORDIC_STAGES + 1];

  always_comb begin
    cst[0].vld  = s4_vld_r;
    cst[0].flip = s4_flip_r;
    cst[0].dx   = s4_dx_r;
    cst[0].dy   = s4_dy_r;
    cst[0].x    = prc_pkg::CORDIC_GAIN;
    cst[0].y    = '0;
    cst[0].z    = s4_z_r;
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    prc_cordic_stage #(
      .STAGE_IDX(g)
    ) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .stage_i(cst[g]),
      .stage_o(cst[g + 1])
    );
  end

  // trig stage: undo the half-turn fold
  prc_pkg::prc_cordic_t cend;
  logic signed [32:0]   x_ext;
  logic signed [32:0]   y_ext;
  logic                 tr_vld_r;
  logic signed [32:0]   tr_cs_r;
  logic signed [32:0]   tr_sn_r;
  logic signed [32:0]   tr_dx_r;
  logic signed [32:0]   tr_dy_r;

  assign cend  = cst[CORDIC_STAGES];
  assign x_ext = {cend.x[31], cend.x};
  assign y_ext = {cend.y[31], cend.y};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tr_vld_r <= 1'b0;
    end else begin
      tr_vld_r <= cend.vld;
      tr_cs_r  <= cend.flip ? -x_ext : x_ext;
      tr_sn_r  <= cend.flip ? -y_ext : y_ext;
      tr_dx_r  <= cend.dx;
      tr_dy_r  <= cend.dy;
    end
  end

  // multiply stage
  logic               mu_vld_r;
  logic signed [65:0] mu_xc_r;
  logic signed [65:0] mu_ys_r;
  logic signed [65:0] mu_xs_r;
  logic signed [65:0] mu_yc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_vld_r <= 1'b0;
    end else begin
      mu_vld_r <= tr_vld_r;
      mu_xc_r  <= tr_dx_r * tr_cs_r;
      mu_ys_r  <= tr_dy_r * tr_sn_r;
      mu_xs_r  <= tr_dx_r * tr_sn_r;
      mu_yc_r  <= tr_dy_r * tr_cs_r;
    end
  end

  // sum stage: combine products and round to Q16.16
  logic signed [66:0] rx_full;
  logic signed [66:0] ry_full;
  logic               sm_vld_r;
  logic signed [37:0] sm_rx_r;
  logic signed [37:0] sm_ry_r;

  assign rx_full = {mu_xc_r[65], mu_xc_r} - {mu_ys_r[65], mu_ys_r} + ROUND_HALF;
  assign ry_full = {mu_xs_r[65], mu_xs_r} + {mu_yc_r[65], mu_yc_r} + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sm_vld_r <= 1'b0;
    end else begin
      sm_vld_r <= mu_vld_r;
      sm_rx_r  <= rx_full[66:29];
      sm_ry_r  <= ry_full[66:29];
    end
  end

  // output stage: move back by center and clamp
  logic signed [38:0] ox_sum;
  logic signed [38:0] oy_sum;
  logic               ox_hi;
  logic               ox_lo;
  logic               oy_hi;
  logic               oy_lo;
  logic               out_valid_r;
  logic signed [31:0] out_rotated_x_r;
  logic signed [31:0] out_rotated_y_r;
  logic               out_saturated_r;

  always_comb begin
    ox_sum = {sm_rx_r[37], sm_rx_r} + {{7{center_x_r[31]}}, center_x_r};
    oy_sum = {sm_ry_r[37], sm_ry_r} + {{7{center_y_r[31]}}, center_y_r};
    ox_hi  = !ox_sum[38] && (ox_sum[37:31] != 7'd0);
    ox_lo  = ox_sum[38] && (ox_sum[37:31] != 7'h7F);
    oy_hi  = !oy_sum[38] && (oy_sum[37:31] != 7'd0);
    oy_lo  = oy_sum[38] && (oy_sum[37:31] != 7'h7F);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r     <= sm_vld_r;
      out_rotated_x_r <= ox_hi ? SAT_MAX : (ox_lo ? SAT_MIN : ox_sum[31:0]);
      out_rotated_y_r <= oy_hi ? SAT_MAX : (oy_lo ? SAT_MIN : oy_sum[31:0]);
      out_saturated_r <= ox_hi | ox_lo | oy_hi | oy_lo;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_rotated_x = out_rotated_x_r;
  assign out_rotated_y = out_rotated_y_r;
  assign out_saturated = out_saturated_r;

  `PRC_ASSERT_IMPLY(a_fold_in_range, clk, rst_n, s1_vld_r, s1_mag_r <= QUARTER_MAG, "fold above quarter turn")
  `PRC_ASSERT_NEXT(a_item_enters_cordic, clk, rst_n, s4_vld_r, cst[1].vld, "item lost entering CORDIC")
  `PRC_ASSERT_IMPLY(a_sat_at_limit, clk, rst_n, out_valid && out_saturated, out_rotated_x == SAT_MAX || out_rotated_x == SAT_MIN || out_rotated_y == SAT_MAX || out_rotated_y == SAT_MIN, "saturated flag without clamped coordinate")

endmodule

`default_nettype wire
